[src/tcct_pkg.sv]
// ----------------------------------------------------------------------------
// tcct_pkg: shared types and constants for the text console cursor tracker
// Item and result structs, character codes, register indexes, FSM states.
// ----------------------------------------------------------------------------
package tcct_pkg;

  localparam int COORD_BITS    = 12;
  localparam int HISTORY_DEPTH = 256;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int HIST_CW       = HIST_AW + 1;
  localparam int CODE_BITS     = 21;
  localparam int GLYPH_BITS    = 8;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 12;
  localparam int DIV_STEPS     = COORD_BITS;
  localparam int DIV_CW        = $clog2(DIV_STEPS + 1);

  // character codes
  localparam logic [CODE_BITS-1:0] CH_NUL       = CODE_BITS'(0);
  localparam logic [CODE_BITS-1:0] CH_BACKSPACE = CODE_BITS'(8);
  localparam logic [CODE_BITS-1:0] CH_TAB       = CODE_BITS'(9);
  localparam logic [CODE_BITS-1:0] CH_NEWLINE   = CODE_BITS'(10);
  localparam logic [CODE_BITS-1:0] CH_RETURN    = CODE_BITS'(13);

  // item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_HOME = 1'b1;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_WIN_LEFT    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_WIN_TOP     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_WIN_RIGHT   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_WIN_BOTTOM  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_LINE_HEIGHT = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SPACE_WIDTH = 3'd5;

  typedef struct packed {
    logic                  kind;
    logic [CODE_BITS-1:0]  char_code;
    logic [GLYPH_BITS-1:0] glyph_width;
  } tcct_in_t;

  typedef struct packed {
    logic                  rect_valid;
    logic [COORD_BITS-1:0] rect_left;
    logic [COORD_BITS-1:0] rect_top;
    logic [COORD_BITS-1:0] rect_right;
    logic [COORD_BITS-1:0] rect_bottom;
    logic                  scrolled;
    logic [COORD_BITS-1:0] cursor_x_out;
    logic [COORD_BITS-1:0] cursor_y_out;
  } tcct_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WAIT,
    ST_FIN
  } tcct_state_t;

endpackage

[src/text_console_cursor_tracker.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_tracker: cursor tracking for a pixel text console
// Flow: an accepted transaction passes through WAIT, or DIV for a tab
//   (12 restoring-divider steps for the tab stop), then FIN into the result register.
// Only one transaction is in flight: a new one is taken in IDLE once FIN commits;
//   the shared divider and the registered read of the x history RAM require this.
// Reset: synchronous, active low; cursor, history count and FSM clear,
//   window registers load their defaults. History RAM contents stay as is.
// ----------------------------------------------------------------------------
module text_console_cursor_tracker
  import tcct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // item channel
  input  logic              in_valid,
  output logic              in_ready,
  input  tcct_in_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output tcct_out_t         out_data,
  // configuration
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int CW = COORD_BITS;

  // window registers
  logic [CW-1:0] win_left_r, win_top_r, win_right_r, win_bottom_r;
  logic [7:0]    line_height_r, space_width_r;

  // architectural state
  logic [CW-1:0]      cursor_x_r, cursor_x_nxt;
  logic [CW-1:0]      cursor_y_r, cursor_y_nxt;
  logic [HIST_CW-1:0] hist_cnt_r, hist_cnt_nxt;

  tcct_state_t state_r, state_nxt;
  tcct_in_t    item_r;

  // shared divider: remainder, dividend shift, low quotient bits, step count
  logic [7:0]        rem_r;
  logic [CW-1:0]     dvd_r;
  logic [2:0]        quo_r;
  logic [DIV_CW-1:0] div_cnt_r;

  logic      out_valid_r;
  tcct_out_t out_r, res;

  logic in_fire, commit, div_run;

  // history RAM ports
  logic               hist_we;
  logic [HIST_AW-1:0] hist_waddr, hist_raddr;
  logic [CW-1:0]      hist_wdata, hist_rdata;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r    <= CW'(0);
      win_top_r     <= CW'(0);
      win_right_r   <= CW'(640);
      win_bottom_r  <= CW'(480);
      line_height_r <= 8'd16;
      space_width_r <= 8'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIN_LEFT:    win_left_r    <= cfg_wdata[CW-1:0];
        REG_WIN_TOP:     win_top_r     <= cfg_wdata[CW-1:0];
        REG_WIN_RIGHT:   win_right_r   <= cfg_wdata[CW-1:0];
        REG_WIN_BOTTOM:  win_bottom_r  <= cfg_wdata[CW-1:0];
        REG_LINE_HEIGHT: line_height_r <= cfg_wdata[7:0];
        REG_SPACE_WIDTH: space_width_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: IDLE takes a transaction; tabs run the divider, everything
  // else passes through WAIT so the history read data lands; FIN
  // commits the result once the output register is free.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_data.kind == KIND_CHAR && in_data.char_code == CH_TAB)
                      ? ST_DIV : ST_WAIT;
        end
      end
      ST_DIV: begin
        if (div_cnt_r == DIV_CW'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_WAIT: state_nxt = ST_FIN;
      ST_FIN: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    div_run  = (state_r == ST_DIV);
    commit   = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  end

  assign in_fire = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // shared restoring divider: (cursor_x - win_left) / space_width, one
  // quotient bit per cycle; only the low three quotient bits matter for the
  // eight-column tab stop.
  // ---------------------------------------------------------------------------
  logic [7:0] sw_eff;
  logic [8:0] div_shift;
  logic [9:0] div_diff;
  logic       div_ge;

  assign sw_eff    = (space_width_r == 8'd0) ? 8'd1 : space_width_r;
  assign div_shift = {rem_r, dvd_r[CW-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b0, sw_eff};
  assign div_ge    = !div_diff[9];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rem_r     <= 8'd0;
      dvd_r     <= cursor_x_r - win_left_r;
      quo_r     <= 3'd0;
      div_cnt_r <= DIV_CW'(DIV_STEPS);
    end else if (div_run) begin
      rem_r     <= div_ge ? div_diff[7:0] : div_shift[7:0];
      dvd_r     <= {dvd_r[CW-2:0], 1'b0};
      quo_r     <= {quo_r[1:0], div_ge};
      div_cnt_r <= div_cnt_r - DIV_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // x history
  // ---------------------------------------------------------------------------
  logic [HIST_CW-1:0] cnt_eff;

  // a full stack restarts at empty before the item is handled
  assign cnt_eff    = hist_cnt_r[HIST_CW-1] ? HIST_CW'(0) : hist_cnt_r;
  assign hist_raddr = HIST_AW'(cnt_eff - HIST_CW'(1));

  tcct_ram #(
    .WIDTH(CW),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (hist_we),
    .waddr(hist_waddr),
    .wdata(hist_wdata),
    .raddr(hist_raddr),
    .rdata(hist_rdata)
  );

  // ---------------------------------------------------------------------------
  // result and next state, evaluated in FIN
  // ---------------------------------------------------------------------------
  logic          nl_scroll, wrap, push;
  logic [CW-1:0] lh_w, lh7, y_nl, px, py, adv, step;
  logic [3:0]    tab_cols;

  always_comb begin
    lh_w      = {{(CW-8){1'b0}}, line_height_r};
    lh7       = {lh_w[CW-4:0], 3'b000} - lh_w;
    // newline scrolls by eight lines first when the next line would pass the bottom
    nl_scroll = ({1'b0, cursor_y_r} + {1'b0, lh_w}) >= {1'b0, win_bottom_r};
    y_nl      = nl_scroll ? (cursor_y_r - lh7) : (cursor_y_r + lh_w);

    wrap = ({1'b0, cursor_x_r} + {{(CW-7){1'b0}}, item_r.glyph_width})
           >= {1'b0, win_right_r};
    px   = wrap ? win_left_r : cursor_x_r;
    py   = wrap ? y_nl : cursor_y_r;

    tab_cols = 4'd8 - {1'b0, quo_r};
    adv      = {{(CW-8){1'b0}}, sw_eff} * {{(CW-4){1'b0}}, tab_cols};

    res          = '0;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    hist_cnt_nxt = cnt_eff;
    push         = 1'b0;
    hist_waddr   = cnt_eff[HIST_AW-1:0];
    hist_wdata   = cursor_x_r;
    step         = '0;

    priority if (item_r.kind == KIND_HOME) begin
      cursor_x_nxt = win_left_r;
      cursor_y_nxt = win_top_r;
      hist_cnt_nxt = '0;
    end else if (item_r.char_code == CH_NEWLINE) begin
      res.scrolled = nl_scroll;
      cursor_x_nxt = win_left_r;
      cursor_y_nxt = y_nl;
      hist_cnt_nxt = '0;
    end else if (item_r.char_code == CH_RETURN) begin
      cursor_x_nxt = win_left_r;
      hist_cnt_nxt = '0;
    end else if (item_r.char_code == CH_TAB) begin
      push            = 1'b1;
      res.rect_valid  = 1'b1;
      res.rect_left   = cursor_x_r;
      res.rect_top    = cursor_y_r;
      res.rect_right  = cursor_x_r + adv;
      res.rect_bottom = cursor_y_r + lh_w;
      cursor_x_nxt    = cursor_x_r + adv;
      hist_cnt_nxt    = cnt_eff + HIST_CW'(1);
    end else if (item_r.char_code == CH_BACKSPACE) begin
      if (cnt_eff != '0) begin
        res.rect_valid  = 1'b1;
        res.rect_left   = hist_rdata;
        res.rect_top    = cursor_y_r;
        res.rect_right  = cursor_x_r;
        res.rect_bottom = cursor_y_r + lh_w;
        cursor_x_nxt    = hist_rdata;
        hist_cnt_nxt    = cnt_eff - HIST_CW'(1);
      end
    end else if (item_r.char_code == CH_NUL) begin
      hist_cnt_nxt = cnt_eff;
    end else begin
      // printable: wrap to a new line first if the glyph would reach or pass the right edge
      step            = {{(CW-8){1'b0}}, item_r.glyph_width};
      push            = 1'b1;
      hist_waddr      = wrap ? '0 : cnt_eff[HIST_AW-1:0];
      hist_wdata      = px;
      res.scrolled    = wrap && nl_scroll;
      res.rect_valid  = 1'b1;
      res.rect_left   = px;
      res.rect_top    = py;
      res.rect_right  = px + step;
      res.rect_bottom = py + lh_w;
      cursor_x_nxt    = px + step;
      cursor_y_nxt    = py;
      hist_cnt_nxt    = (wrap ? HIST_CW'(0) : cnt_eff) + HIST_CW'(1);
    end

    res.cursor_x_out = cursor_x_nxt;
    res.cursor_y_out = cursor_y_nxt;
    hist_we          = commit && push;
  end

  // ---------------------------------------------------------------------------
  // state and output registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      hist_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        cursor_x_r  <= cursor_x_nxt;
        cursor_y_r  <= cursor_y_nxt;
        hist_cnt_r  <= hist_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_DIV || state_r == ST_WAIT))
    else $error("accepted transaction did not start work");

  a_hist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hist_cnt_r <= HIST_CW'(HISTORY_DEPTH))
    else $error("history count beyond depth");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    div_run |-> div_cnt_r != '0)
    else $error("divider running with no steps left");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ready) |=> state_r == ST_FIN)
    else $error("result committed over an untaken one");

endmodule

[src/tcct_ram.sv]
// ----------------------------------------------------------------------------
// tcct_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
